@@ rtl/slru_pkg.sv @@
// Shared types and constants for the second-oldest timestamp replacement block.
// Holds the channel payload structs, the decoded command and the state encoding.
// No dependencies.
`default_nettype none

package slru_pkg;

   typedef enum logic [1:0] {
      ACT_TOUCH      = 2'd0,
      ACT_INSERT     = 2'd1,
      ACT_INVALIDATE = 2'd2,
      ACT_VICTIM     = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  set_index;
      logic [2:0]  way;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic       victim_valid;
      logic [2:0] victim_way;
   } rsp_type;

   // command handed from the front to the back; set already wrapped to a row
   typedef struct packed {
      action_type  act;
      logic [5:0]  set_row;
      logic [2:0]  way;
      logic        way_ok;
      logic [31:0] now;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOAD,
      BK_MERGE,
      BK_MATCH
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/slru_fifo.sv @@
// Two-entry queue of raw words, used between front and back and for results.
// No package dependencies.
`default_nettype none

module slru_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      out_data,
   output logic                  empty
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign out_data = data_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/slru_front.sv @@
// Front end: accept requests, decode the action, wrap the set, check the way.
// Depends on slru_pkg.
`default_nettype none

module slru_front
   import slru_pkg::*;
#(
   parameter int NUM_SETS = 64,
   parameter int NUM_WAYS = 8
) (
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   input  wire logic    cmd_full,
   input  wire logic    clearing,
   output logic         cmd_push,
   output cmd_type      cmd_data
);

   logic [5:0] set_row;
   int         cnt;

   assign full     = cmd_full || clearing;
   assign cmd_push = push && !full;

   // set_index modulo NUM_SETS as a constant lookup over the 64 codes
   always_comb begin
      set_row = 6'd0;
      cnt     = 0;
      for (int i = 0; i < 64; i++) begin
         if (req_data.set_index == 6'(i)) begin
            set_row = 6'(cnt);
         end
         cnt = (cnt == NUM_SETS - 1) ? 0 : cnt + 1;
      end
   end

   always_comb begin
      cmd_data.act     = action_type'(req_data.action);
      cmd_data.set_row = set_row;
      cmd_data.way     = req_data.way;
      cmd_data.way_ok  = ({29'd0, req_data.way} < 32'(NUM_WAYS));
      cmd_data.now     = req_data.now;
   end

endmodule

`default_nettype wire

@@ rtl/slru_back.sv @@
// Back end: timestamp memory, clearing pass, second-oldest search and latch.
// Depends on slru_pkg.
`default_nettype none

module slru_back
   import slru_pkg::*;
#(
   parameter int NUM_SETS  = 64,
   parameter int NUM_WAYS  = 8,
   parameter int TIME_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   input  wire logic    rsp_full,
   output logic         rsp_push,
   output rsp_type      rsp_data,
   output logic         clearing
);

   localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int LVL      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 0;
   localparam int LEAVES   = 1 << LVL;
   localparam int LVL_CW   = (LVL > 1) ? $clog2(LVL) : 1;
   localparam int ROW_BITS = NUM_WAYS * TIME_BITS;
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

   logic [ROW_BITS-1:0]  mem [NUM_SETS];
   logic [ROW_BITS-1:0]  rd_row_ff;

   back_state_type       state_ff, state_in;
   logic [SET_W-1:0]     clr_ff;
   logic [LVL_CW-1:0]    lvl_ff;
   logic [TIME_BITS-1:0] latch_ff;
   logic [TIME_BITS-1:0] lo_ff [LEAVES];
   logic [TIME_BITS-1:0] hi_ff [LEAVES];
   logic [TIME_BITS-1:0] lo_in [LEAVES];
   logic [TIME_BITS-1:0] hi_in [LEAVES];

   logic                 wr_en;
   logic [SET_W-1:0]     wr_addr;
   logic [NUM_WAYS-1:0]  wr_mask;
   logic [TIME_BITS-1:0] wr_val;
   logic                 rd_en;
   logic [SET_W-1:0]     cmd_row;
   logic [TIME_BITS-1:0] ins_val;
   logic [TIME_BITS-1:0] target;
   logic [WAY_W-1:0]     chosen;

   assign cmd_row  = SET_W'(cmd.set_row);
   assign ins_val  = (latch_ff == TMAX) ? TMAX : latch_ff + TIME_BITS'(1);
   assign target   = (NUM_WAYS >= 2) ? hi_ff[0] : lo_ff[0];
   assign clearing = (state_ff == BK_CLEAR);

   // highest way holding the target value
   always_comb begin
      chosen = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (rd_row_ff[w*TIME_BITS +: TIME_BITS] == target) begin
            chosen = WAY_W'(w);
         end
      end
   end

   // load leaves from the row, or merge one tree level of (lowest, second) pairs
   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         lo_in[i] = lo_ff[i];
         hi_in[i] = hi_ff[i];
      end
      if (state_ff == BK_LOAD) begin
         for (int i = 0; i < LEAVES; i++) begin
            lo_in[i] = TMAX;
            hi_in[i] = TMAX;
         end
         for (int w = 0; w < NUM_WAYS; w++) begin
            lo_in[w] = rd_row_ff[w*TIME_BITS +: TIME_BITS];
         end
      end else begin
         for (int i = 0; i < LEAVES / 2; i++) begin
            if (lo_ff[2*i] <= lo_ff[2*i+1]) begin
               lo_in[i] = lo_ff[2*i];
               hi_in[i] = (hi_ff[2*i] < lo_ff[2*i+1]) ? hi_ff[2*i] : lo_ff[2*i+1];
            end else begin
               lo_in[i] = lo_ff[2*i+1];
               hi_in[i] = (lo_ff[2*i] < hi_ff[2*i+1]) ? lo_ff[2*i] : hi_ff[2*i+1];
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!cmd_empty && cmd.act == ACT_VICTIM) begin
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            state_in = (LVL == 0) ? BK_MATCH : BK_MERGE;
         end
         BK_MERGE: begin
            if (lvl_ff == LVL_CW'(LVL - 1)) begin
               state_in = BK_MATCH;
            end
         end
         BK_MATCH: begin
            if (!rsp_full) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      wr_en    = 1'b0;
      wr_addr  = cmd_row;
      wr_mask  = '0;
      wr_val   = '0;
      rd_en    = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_mask = '1;
         end
         BK_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.act == ACT_VICTIM) begin
                  cmd_pop = 1'b1;
                  rd_en   = 1'b1;
               end else if (!rsp_full) begin
                  cmd_pop  = 1'b1;
                  rsp_push = 1'b1;
                  wr_en    = cmd.way_ok;
                  wr_mask[WAY_W'(cmd.way)] = 1'b1;
                  unique case (cmd.act)
                     ACT_TOUCH:  wr_val = TIME_BITS'(cmd.now);
                     ACT_INSERT: wr_val = ins_val;
                     default:    wr_val = '0;
                  endcase
               end
            end
         end
         BK_MATCH: begin
            if (!rsp_full) begin
               rsp_push              = 1'b1;
               rsp_data.victim_valid = 1'b1;
               rsp_data.victim_way   = 3'(chosen);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (wr_mask[w]) begin
               mem[wr_addr][w*TIME_BITS +: TIME_BITS] <= wr_val;
            end
         end
      end
      if (rd_en) begin
         rd_row_ff <= mem[cmd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_LOAD || state_ff == BK_MERGE) begin
         for (int i = 0; i < LEAVES; i++) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
         lvl_ff   <= '0;
         latch_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CLEAR) begin
            clr_ff <= clr_ff + SET_W'(1);
         end
         if (state_ff == BK_LOAD) begin
            lvl_ff <= '0;
         end else if (state_ff == BK_MERGE) begin
            lvl_ff <= lvl_ff + LVL_CW'(1);
         end
         if (state_ff == BK_MATCH && !rsp_full) begin
            latch_ff <= target;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/second_lru_way_replacement_top.sv @@
// Top level of the second-oldest timestamp replacement block.
// Depends on slru_pkg, slru_front, slru_fifo and slru_back.
`default_nettype none

// Keeps a last-touch timestamp per way of every set and answers one result
// per request, in request order. A touch stores now, an invalidate stores
// zero, an insert stores the last victim value plus one (saturating), and a
// victim request returns the highest way holding the second smallest
// timestamp of the set (duplicates count). Requests enter through a
// push/full queue and results leave through an empty/pop queue; a two-entry
// command queue separates the decoding front from the memory back end, so
// requests keep being taken while a result waits to transfer. In the back
// end a touch, insert or invalidate is a single masked write of one way. A
// victim request goes through a set-wide memory read, a load of the compare
// tree, a merge of (lowest, second lowest) pairs at each tree level, and a
// match step that waits for room in the result queue, then finds the way
// and latches the value; the back end takes no new command until it is
// done. Both queues are registered: a command waits in the command queue
// and a result in the result queue before it transfers. After reset a
// clearing pass zeroes the memory one set per cycle; full stays high
// meanwhile. Set indexes wrap modulo NUM_SETS; ways at or beyond NUM_WAYS
// leave the state unchanged.
module second_lru_way_replacement_top
   import slru_pkg::*;
#(
   parameter int NUM_SETS  = 64,
   parameter int NUM_WAYS  = 8,
   parameter int TIME_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   input  wire logic    pop,
   output rsp_type      rsp_data,
   output logic         empty
);

   localparam int CMD_BITS = $bits(cmd_type);
   localparam int RSP_BITS = $bits(rsp_type);

   logic    cmd_push;
   cmd_type cmd_in;
   logic    cmd_full;
   cmd_type cmd_out;
   logic    cmd_empty;
   logic    cmd_pop;
   logic    clearing;
   logic    rsp_push;
   rsp_type rsp_in;
   logic    rsp_full;

   // decode and classify; hold off while the queue is full or memory clears
   slru_front #(
      .NUM_SETS (NUM_SETS),
      .NUM_WAYS (NUM_WAYS)
   ) u_front (
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .cmd_full (cmd_full),
      .clearing (clearing),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   // decoupling queue between front and back
   slru_fifo #(
      .WIDTH (CMD_BITS)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .in_data  (cmd_in),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .out_data (cmd_out),
      .empty    (cmd_empty)
   );

   // memory, victim search and timestamp updates
   slru_back #(
      .NUM_SETS  (NUM_SETS),
      .NUM_WAYS  (NUM_WAYS),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in),
      .clearing  (clearing)
   );

   // result queue; the oldest result sits on rsp_data until it transfers
   slru_fifo #(
      .WIDTH (RSP_BITS)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .in_data  (rsp_in),
      .full     (rsp_full),
      .pop      (pop),
      .out_data (rsp_data),
      .empty    (empty)
   );

endmodule

`default_nettype wire
